/* rtl/pts_pkg.sv */
// pts_pkg: shared constants, types and codes for the priority task scheduler
// no dependencies; imported by pts_walk_unit, priority_task_scheduler and the testbench
package pts_pkg;

  localparam int MAX_TASKS = 9;
  localparam int TICK_BITS = 32;
  localparam int ADDR_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    ACT_CREATE   = 3'd0,
    ACT_DELAY    = 3'd1,
    ACT_SUSPEND  = 3'd2,
    ACT_ACTIVATE = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_RUNNING   = 2'd1,
    MODE_WAITING   = 2'd2,
    MODE_SUSPENDED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_WAKE,
    S_DISP,
    S_COMMIT,
    S_DONE
  } state_t;

  // per-entry result of the shared walk unit
  typedef struct packed {
    logic                 runnable;
    logic                 waiting;
    logic                 better;
    logic [TICK_BITS-1:0] cd_dec;
    logic                 cd_zero;
  } walk_res_t;

endpackage

/* rtl/pts_walk_unit.sv */
// pts_walk_unit: evaluates one table entry per cycle for the wake and dispatch walks
// depends on pts_pkg
module pts_walk_unit import pts_pkg::*; (
  input  mode_t                mode,
  input  logic [7:0]           prio,
  input  logic [TICK_BITS-1:0] countdown,
  input  logic [7:0]           best_prio,
  input  logic                 found,
  output walk_res_t            res
);

  logic [TICK_BITS-1:0] dec;

  assign dec = countdown - {{(TICK_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    res.runnable = (mode == MODE_READY) || (mode == MODE_RUNNING);
    res.waiting  = (mode == MODE_WAITING);
    // first runnable entry always wins, later ones only on strictly higher priority
    res.better   = res.runnable && (!found || (prio > best_prio));
    res.cd_dec   = dec;
    res.cd_zero  = (dec == '0);
  end

endmodule

/* rtl/priority_task_scheduler.sv */
// priority_task_scheduler: fixed-priority task table with create, delay, suspend,
// activate and tick items; one result item per input item; depends on pts_pkg, pts_walk_unit
// steps: create and unused codes apply then done; other items apply, a wake walk over the
// n tasks for tick only, a dispatch walk over the n tasks, commit and done; output stalls hold done
// one item at a time: the next item is taken only once the result has been loaded for output
// reset: synchronous active-low rst_n clears task count, running index and tick count
module priority_task_scheduler import pts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] task_priority_in, [8] start_suspended, [40:9] delay_ticks,
  // [44:41] target_task, [47:45] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] running_task, [4] switched, [5] create_ok, [9:6] new_task_index,
  // [41:10] tick_count, [47:42] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]     running_r, running_nxt;
  logic [TICK_BITS-1:0] ticks_r, ticks_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [7:0]           best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     pick_r, pick_nxt;
  logic                 sw_r, sw_nxt;
  logic                 ok_r, ok_nxt;
  logic [CNT_W-1:0]     newidx_r, newidx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  action_t              act_r;
  logic [7:0]           prio_in_r;
  logic                 susp_r;
  logic [TICK_BITS-1:0] delay_r;
  logic [3:0]           target_r;

  logic [7:0]           task_prio [0:MAX_TASKS-1];
  mode_t                task_mode [0:MAX_TASKS-1];
  logic [TICK_BITS-1:0] task_cd   [0:MAX_TASKS-1];

  // single table write port
  logic                 wr_mode_en, wr_cd_en, wr_prio_en;
  logic [ADDR_W-1:0]    wr_addr;
  mode_t                wr_mode;
  logic [TICK_BITS-1:0] wr_cd;
  logic [7:0]           wr_prio;

  logic                 in_fire;
  logic                 cur_live;
  logic                 idx_live;
  logic                 out_free;
  walk_res_t            walk;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cur_live   = running_r < total_r;
  assign idx_live   = idx_r < total_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pts_walk_unit u_walk (
    .mode      (task_mode[idx_r[ADDR_W-1:0]]),
    .prio      (task_prio[idx_r[ADDR_W-1:0]]),
    .countdown (task_cd[idx_r[ADDR_W-1:0]]),
    .best_prio (best_r),
    .found     (found_r),
    .res       (walk)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (act_r)
          ACT_DELAY, ACT_SUSPEND, ACT_ACTIVATE: state_nxt = S_DISP;
          ACT_TICK:                             state_nxt = S_WAKE;
          default:                              state_nxt = S_DONE;
        endcase
      end
      S_WAKE: begin
        if (!idx_live) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (!idx_live) state_nxt = S_COMMIT;
      end
      S_COMMIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    total_nxt     = total_r;
    running_nxt   = running_r;
    ticks_nxt     = ticks_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    sw_nxt        = sw_r;
    ok_nxt        = ok_r;
    newidx_nxt    = newidx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    wr_mode_en    = 1'b0;
    wr_cd_en      = 1'b0;
    wr_prio_en    = 1'b0;
    wr_addr       = running_r[ADDR_W-1:0];
    wr_mode       = MODE_READY;
    wr_cd         = delay_r;
    wr_prio       = prio_in_r;

    case (state_r)
      S_IDLE: begin
        sw_nxt     = 1'b0;
        ok_nxt     = 1'b0;
        newidx_nxt = '0;
        idx_nxt    = '0;
        found_nxt  = 1'b0;
        best_nxt   = '0;
      end
      S_APPLY: begin
        pick_nxt = total_r;
        case (act_r)
          ACT_CREATE: begin
            if (total_r < CNT_W'(MAX_TASKS)) begin
              wr_addr    = total_r[ADDR_W-1:0];
              wr_mode_en = 1'b1;
              wr_cd_en   = 1'b1;
              wr_prio_en = 1'b1;
              wr_mode    = susp_r ? MODE_SUSPENDED : MODE_READY;
              wr_cd      = '0;
              total_nxt  = total_r + CNT_W'(1);
              ok_nxt     = 1'b1;
              newidx_nxt = total_r;
            end
          end
          ACT_DELAY: begin
            wr_mode_en = cur_live;
            wr_cd_en   = cur_live;
            wr_mode    = MODE_WAITING;
          end
          ACT_SUSPEND: begin
            wr_mode_en = cur_live;
            wr_mode    = MODE_SUSPENDED;
          end
          ACT_ACTIVATE: begin
            wr_addr    = target_r[ADDR_W-1:0];
            wr_mode_en = CNT_W'(target_r) < total_r;
            wr_mode    = MODE_READY;
          end
          ACT_TICK: begin
            ticks_nxt = ticks_r + {{(TICK_BITS-1){1'b0}}, 1'b1};
          end
          default: begin
          end
        endcase
      end
      S_WAKE: begin
        wr_addr = idx_r[ADDR_W-1:0];
        if (idx_live) begin
          idx_nxt    = idx_r + CNT_W'(1);
          wr_cd_en   = walk.waiting;
          wr_cd      = walk.cd_dec;
          wr_mode_en = walk.waiting && walk.cd_zero;
          wr_mode    = MODE_READY;
        end else begin
          idx_nxt = '0;
        end
      end
      S_DISP: begin
        if (idx_live) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (walk.better) begin
            found_nxt = 1'b1;
            best_nxt  = task_prio[idx_r[ADDR_W-1:0]];
            pick_nxt  = idx_r;
          end
        end
      end
      S_COMMIT: begin
        wr_addr = pick_r[ADDR_W-1:0];
        if (pick_r != running_r) begin
          running_nxt = pick_r;
          sw_nxt      = 1'b1;
          wr_mode_en  = pick_r < total_r;
          wr_mode     = MODE_RUNNING;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[3:0]   = 4'(running_r);
          out_data_nxt[4]     = sw_r;
          out_data_nxt[5]     = ok_r;
          out_data_nxt[9:6]   = 4'(newidx_r);
          out_data_nxt[41:10] = 32'(ticks_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      running_r   <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      sw_r        <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      running_r   <= running_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      sw_r        <= sw_nxt;
      ok_r        <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    newidx_r   <= newidx_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      act_r     <= action_t'(in_tuser[2:0]);
      prio_in_r <= in_tdata[7:0];
      susp_r    <= in_tdata[8];
      delay_r   <= TICK_BITS'(in_tdata[40:9]);
      target_r  <= in_tdata[44:41];
    end
    if (wr_mode_en) task_mode[wr_addr] <= wr_mode;
    if (wr_cd_en)   task_cd[wr_addr]   <= wr_cd;
    if (wr_prio_en) task_prio[wr_addr] <= wr_prio;
  end

  // running index is either a live task or the "none" value equal to the count
  a_running_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r <= total_r)
    else $error("running index beyond task count");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  // table only grows, one entry per create
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == $past(total_r)) || (total_r == $past(total_r) + CNT_W'(1)))
    else $error("task count changed by more than one");

  // a result is only loaded once the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r && $stable(out_data_r))
    else $error("pending result item overwritten");

endmodule

/* test/tb_priority_task_scheduler.sv */
// tb_priority_task_scheduler: self-checking bench for the priority task scheduler,
// directed and random items against a cycle-free model of the task table
// depends on pts_pkg and the priority_task_scheduler rtl
module tb_priority_task_scheduler;
  import pts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
  localparam int         IDLE_LIMIT       = 4000;
  localparam int         DRAIN_CYCLES     = 40;
  localparam int         RANDOM_ITEMS     = 620;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  prio;
    logic        susp;
    logic [31:0] ticks;
    logic [3:0]  target;
  } sched_cmd_t;

  // packed so that running_task sits in the low bits, as on out_tdata
  typedef struct packed {
    logic [31:0] ticks;
    logic [3:0]  new_idx;
    logic        ok;
    logic        sw;
    logic [3:0]  running;
  } sched_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  priority_task_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the task table
  logic [3:0]           task_total = '0;
  logic [3:0]           run_idx = '0;
  logic [TICK_BITS-1:0] tick_now = '0;
  logic [7:0]           task_prio [MAX_TASKS];
  mode_t                task_mode [MAX_TASKS];
  logic [TICK_BITS-1:0] task_cd [MAX_TASKS];

  sched_cmd_t cmd_q [$];
  sched_res_t expect_q [$];

  int  err_cnt = 0;
  int  idle_cycles = 0;
  bit  drv_busy = 1'b0;
  bit  item_taken = 1'b0;
  bit  res_taken = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  in_calm = 0;
  int  out_calm = 0;

  function automatic bit dispatch_task();
    logic [3:0] pick;
    int         best;
    pick = task_total;
    best = -1;
    for (int i = 0; i < task_total; i++) begin
      if ((task_mode[i] == MODE_READY || task_mode[i] == MODE_RUNNING) &&
          int'(task_prio[i]) > best) begin
        best = int'(task_prio[i]);
        pick = 4'(i);
      end
    end
    if (pick == run_idx) return 1'b0;
    run_idx = pick;
    if (pick < task_total) task_mode[pick] = MODE_RUNNING;
    return 1'b1;
  endfunction

  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    bit         cur_live;
    r = '0;
    cur_live = run_idx < task_total;
    case (c.act)
      ACT_CREATE: begin
        if (task_total < MAX_TASKS) begin
          task_mode[task_total] = c.susp ? MODE_SUSPENDED : MODE_READY;
          task_prio[task_total] = c.prio;
          task_cd[task_total]   = '0;
          r.ok      = 1'b1;
          r.new_idx = task_total;
          task_total++;
        end
      end
      ACT_DELAY: begin
        if (cur_live) begin
          task_mode[run_idx] = MODE_WAITING;
          task_cd[run_idx]   = c.ticks;
        end
        r.sw = dispatch_task();
      end
      ACT_SUSPEND: begin
        if (cur_live) task_mode[run_idx] = MODE_SUSPENDED;
        r.sw = dispatch_task();
      end
      ACT_ACTIVATE: begin
        if (c.target < task_total) task_mode[c.target] = MODE_READY;
        r.sw = dispatch_task();
      end
      ACT_TICK: begin
        tick_now++;
        // a zero countdown wraps to all ones here
        for (int i = 0; i < task_total; i++) begin
          if (task_mode[i] == MODE_WAITING) begin
            task_cd[i]--;
            if (task_cd[i] == '0) task_mode[i] = MODE_READY;
          end
        end
        r.sw = dispatch_task();
      end
      default: begin
      end
    endcase
    r.running = run_idx;
    r.ticks   = tick_now;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic push_cmd(logic [2:0] a, logic [7:0] p, logic s, logic [31:0] t,
                          logic [3:0] g);
    sched_cmd_t c;
    c.act    = a;
    c.prio   = p;
    c.susp   = s;
    c.ticks  = t;
    c.target = g;
    cmd_q.push_back(c);
  endtask

  // driver
  always @(negedge clk) begin
    sched_cmd_t c;
    if (rst_n) begin
      if (item_taken) begin
        item_taken = 1'b0;
        drv_busy   = 1'b0;
        in_gap     = pick_gap(in_calm);
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q.pop_front();
          in_tdata <= {3'b000, c.target, c.ticks, c.susp, c.prio};
          in_tuser <= c.act;
          drv_busy = 1'b1;
        end
      end
      in_tvalid <= drv_busy;

      if (res_taken) begin
        res_taken = 1'b0;
        out_gap   = pick_gap(out_calm);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin
    sched_cmd_t c;
    sched_res_t got;
    sched_res_t exp_res;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        c.prio   = in_tdata[7:0];
        c.susp   = in_tdata[8];
        c.ticks  = in_tdata[40:9];
        c.target = in_tdata[44:41];
        c.act    = in_tuser;
        expect_q.push_back(schedule_step(c));
        item_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        res_taken = 1'b1;
        moved = 1'b1;
        if (expect_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result item: %h", out_tdata);
          err_cnt++;
        end else begin
          exp_res = expect_q.pop_front();
          if (got.running !== exp_res.running || got.sw !== exp_res.sw ||
              got.ok !== exp_res.ok || got.new_idx !== exp_res.new_idx ||
              got.ticks !== exp_res.ticks) begin
            if (err_cnt < 10)
              $display("result mismatch: exp run=%0d sw=%0b ok=%0b idx=%0d tick=%0d, got run=%0d sw=%0b ok=%0b idx=%0d tick=%0d",
                       exp_res.running, exp_res.sw, exp_res.ok, exp_res.new_idx,
                       exp_res.ticks, got.running, got.sw, got.ok, got.new_idx,
                       got.ticks);
            err_cnt++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    logic [2:0]  a;
    logic [31:0] t;
    logic [3:0]  g;

    // nothing in the table yet: unused codes, no current task, target out of range
    for (int k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
      push_cmd(3'(k), 8'hFF, 1'b1, 32'hFFFF_FFFF, 4'hF);
    push_cmd(ACT_DELAY, 8'h00, 1'b0, 32'd3, 4'd0);
    push_cmd(ACT_SUSPEND, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_ACTIVATE, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_TICK, 8'h00, 1'b0, 32'd0, 4'd0);
    // priority extremes, a tie at the top and one suspended at creation
    push_cmd(ACT_CREATE, 8'd0, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd255, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd128, 1'b1, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd255, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_TICK, 8'h00, 1'b0, 32'd0, 4'd0);
    // zero delay wraps, then a short delay that expires and preempts
    push_cmd(ACT_DELAY, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_DELAY, 8'h00, 1'b0, 32'd2, 4'd0);
    push_cmd(ACT_TICK, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_TICK, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_ACTIVATE, 8'h00, 1'b0, 32'd0, 4'd3);
    push_cmd(ACT_ACTIVATE, 8'h00, 1'b0, 32'd0, 4'd2);
    push_cmd(ACT_SUSPEND, 8'h00, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_ACTIVATE, 8'h00, 1'b0, 32'd0, 4'd15);
    push_cmd(ACT_ACTIVATE, 8'h00, 1'b0, 32'd0, 4'd1);
    push_cmd(ACT_DELAY, 8'h00, 1'b0, 32'hFFFF_FFFF, 4'd0);
    // fill the table, then one create too many
    push_cmd(ACT_CREATE, 8'd1, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd254, 1'b1, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd127, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd64, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd200, 1'b0, 32'd0, 4'd0);
    push_cmd(ACT_CREATE, 8'd90, 1'b0, 32'd0, 4'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) a = ACT_CREATE;
      else if (r < 28) a = ACT_DELAY;
      else if (r < 38) a = ACT_SUSPEND;
      else if (r < 58) a = ACT_ACTIVATE;
      else if (r < 95) a = ACT_TICK;
      else a = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      // mostly short delays so that waiting tasks wake within the run
      r = $urandom_range(0, 99);
      if (r < 10) t = '0;
      else if (r < 80) t = $urandom_range(1, 6);
      else if (r < 90) t = $urandom_range(7, 40);
      else t = $urandom();
      if ($urandom_range(0, 3) == 0) g = 4'($urandom_range(0, 15));
      else g = 4'($urandom_range(0, MAX_TASKS - 1));
      push_cmd(a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), t, g);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || drv_busy) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expect_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
